[src/ipv4p_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Types, character codes and helpers for the dotted IPv4 address parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

	localparam int unsigned CharWidth = 8;
	localparam int unsigned AddrWidth = 32;

	// parse phase, one-hot
	typedef enum logic [3:0] {
		PH_START   = 4'b0001,
		PH_ZERO    = 4'b0010,
		PH_DIGITS  = 4'b0100,
		PH_DISCARD = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2
	} radix_t;

	localparam logic [CharWidth-1:0] ChNul    = 8'h00;
	localparam logic [CharWidth-1:0] ChTab    = 8'h09;
	localparam logic [CharWidth-1:0] ChCr     = 8'h0d;
	localparam logic [CharWidth-1:0] ChSpace  = 8'h20;
	localparam logic [CharWidth-1:0] ChDot    = 8'h2e;
	localparam logic [CharWidth-1:0] ChZero   = 8'h30;
	localparam logic [CharWidth-1:0] ChNine   = 8'h39;
	localparam logic [CharWidth-1:0] ChUpperA = 8'h41;
	localparam logic [CharWidth-1:0] ChUpperF = 8'h46;
	localparam logic [CharWidth-1:0] ChUpperX = 8'h58;
	localparam logic [CharWidth-1:0] ChLowerA = 8'h61;
	localparam logic [CharWidth-1:0] ChLowerF = 8'h66;
	localparam logic [CharWidth-1:0] ChLowerX = 8'h78;

	localparam logic [1:0] MaxClosedParts = 2'd3;

	// part value times radix, by shifts and one add
	function automatic logic [AddrWidth-1:0] scale_part(
		input logic [AddrWidth-1:0] acc,
		input radix_t               rad
	);
		logic [AddrWidth-1:0] res;
		case (rad)
			RX_HEX: res = {acc[AddrWidth-5:0], 4'b0};
			RX_OCT: res = {acc[AddrWidth-4:0], 3'b0};
			default: res = {acc[AddrWidth-4:0], 3'b0} + {acc[AddrWidth-2:0], 1'b0};
		endcase
		return res;
	endfunction

endpackage

[src/dotted_ipv4_address_parser_top.sv]
// ----------------------------------------------------------------------------
// dotted_ipv4_address_parser_top
// Parses classic dotted IPv4 text, one character per transfer, into a
// 32-bit address with an error flag.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   char_code[7:0]
//   out      source     out_valid / out_ready address[31:0], bad_address
//
// One character is taken every cycle while in_ready is high; the parse state
// and, if there is a result, the output register load at the same clock edge.
// in_ready is low only while a result waits in the output register and
// out_ready is low. Reset puts the parser at the start of a new address.
// A terminator (NUL or whitespace) or a malformed character yields one result;
// after a result on any character but NUL, characters are dropped through the next NUL.
// ----------------------------------------------------------------------------
module dotted_ipv4_address_parser_top
	import ipv4p_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CharWidth-1:0] char_code,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [AddrWidth-1:0] address,
	output logic                 bad_address
);

	phase_t               phase_q, phase_nxt;
	radix_t               rad_q, rad_nxt, rad_eff;
	logic [AddrWidth-1:0] acc_q, acc_nxt, acc_eff;
	logic [1:0]           parts_q, parts_nxt;
	logic [7:0]           first_q, first_nxt;
	logic [7:0]           second_q, second_nxt;
	logic [7:0]           third_q, third_nxt;

	logic                 out_valid_q;
	logic [AddrWidth-1:0] address_q;
	logic                 bad_q;

	logic                 in_fire;
	logic                 res_valid;
	logic [AddrWidth-1:0] res_addr;
	logic                 res_bad;

	logic       is_nul, is_x, is_dec, is_upper, is_lower, is_end;
	logic       go;
	logic [3:0] digit;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign is_nul   = (char_code == ChNul);
	assign is_x     = (char_code == ChLowerX) || (char_code == ChUpperX);
	assign is_dec   = (char_code >= ChZero) && (char_code <= ChNine);
	assign is_upper = (char_code >= ChUpperA) && (char_code <= ChUpperF);
	assign is_lower = (char_code >= ChLowerA) && (char_code <= ChLowerF);
	assign is_end   = is_nul || (char_code == ChSpace) ||
		((char_code >= ChTab) && (char_code <= ChCr));
	// letters a-f and A-F have low nibble 1..6
	assign digit    = is_dec ? char_code[3:0] : char_code[3:0] + 4'd9;

	always_comb begin
		logic finish;
		logic fail;
		logic [AddrWidth-1:0] combined;

		phase_nxt  = phase_q;
		rad_nxt    = rad_q;
		acc_nxt    = acc_q;
		parts_nxt  = parts_q;
		first_nxt  = first_q;
		second_nxt = second_q;
		third_nxt  = third_q;
		rad_eff    = rad_q;
		acc_eff    = acc_q;
		go         = 1'b0;
		finish     = 1'b0;
		fail       = 1'b0;
		res_valid  = 1'b0;
		res_addr   = '1;
		res_bad    = 1'b0;

		case (parts_q)
			2'd0:    combined = acc_q;
			2'd1:    combined = {first_q, 24'b0} | acc_q;
			2'd2:    combined = {first_q, second_q, 16'b0} | acc_q;
			default: combined = {first_q, second_q, third_q, 8'b0} | acc_q;
		endcase

		case (phase_q)
			PH_START: begin
				acc_eff   = '0;
				acc_nxt   = '0;
				phase_nxt = PH_DIGITS;
				if (char_code == ChZero) begin
					rad_nxt   = RX_OCT;
					phase_nxt = PH_ZERO;
				end else if (is_x) begin
					rad_nxt = RX_HEX;
				end else begin
					rad_nxt = RX_DEC;
					rad_eff = RX_DEC;
					go      = 1'b1;
				end
			end
			PH_ZERO: begin
				phase_nxt = PH_DIGITS;
				if (is_x) begin
					rad_nxt = RX_HEX;
				end else begin
					go = 1'b1;
				end
			end
			PH_DIGITS: begin
				go = 1'b1;
			end
			default: ;
		endcase

		if (go) begin
			if (is_dec || ((is_upper || is_lower) && rad_eff == RX_HEX)) begin
				acc_nxt = scale_part(acc_eff, rad_eff) + {{(AddrWidth-4){1'b0}}, digit};
			end else if (char_code == ChDot) begin
				if (parts_q == MaxClosedParts) begin
					finish = 1'b1;
					fail   = 1'b1;
				end else begin
					case (parts_q)
						2'd0:    first_nxt  = acc_eff[7:0];
						2'd1:    second_nxt = acc_eff[7:0];
						default: third_nxt  = acc_eff[7:0];
					endcase
					parts_nxt = parts_q + 2'd1;
					phase_nxt = PH_START;
					rad_nxt   = RX_DEC;
					acc_nxt   = '0;
				end
			end else if (is_end) begin
				// start phase reached here means an empty part, value zero
				finish   = 1'b1;
				res_addr = (phase_q == PH_START) ? (combined & ~acc_q) : combined;
			end else begin
				finish = 1'b1;
				fail   = 1'b1;
			end
		end

		if (finish) begin
			res_valid = 1'b1;
			res_bad   = fail;
			if (fail) begin
				res_addr = '1;
			end
			phase_nxt = PH_DISCARD;
		end

		if ((finish || phase_q == PH_DISCARD) && is_nul) begin
			phase_nxt  = PH_START;
			rad_nxt    = RX_DEC;
			acc_nxt    = '0;
			parts_nxt  = '0;
			first_nxt  = '0;
			second_nxt = '0;
			third_nxt  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			rad_q    <= RX_DEC;
			acc_q    <= '0;
			parts_q  <= '0;
			first_q  <= '0;
			second_q <= '0;
			third_q  <= '0;
		end else if (in_fire) begin
			phase_q  <= phase_nxt;
			rad_q    <= rad_nxt;
			acc_q    <= acc_nxt;
			parts_q  <= parts_nxt;
			first_q  <= first_nxt;
			second_q <= second_nxt;
			third_q  <= third_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			address_q <= res_addr;
			bad_q     <= res_bad;
		end
	end

	assign out_valid   = out_valid_q;
	assign address     = address_q;
	assign bad_address = bad_q;

	// an error result always carries the all-ones address
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_q |-> address_q == '1)
		else $error("error result without all-ones address");

	// a NUL always leaves the parser at the start of a fresh address
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_nul |=> phase_q == PH_START && parts_q == 2'd0 && acc_q == '0)
		else $error("parser not cleared after NUL");

	// a result moves the parser to discard or back to start
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res_valid |=> phase_q == PH_DISCARD || phase_q == PH_START)
		else $error("parser kept parsing after a result");

	// characters dropped in discard never produce a result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && phase_q == PH_DISCARD |-> !res_valid)
		else $error("result produced while discarding");

endmodule

[test/dotted_ipv4_address_parser_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dotted_ipv4_address_parser_top_test
// Sends address text one character per transfer, predicts each parsed
// address in a behavioral parser, and checks every result in order; outside
// the back-to-back test both channels idle and stall at random.
// ----------------------------------------------------------------------------
module dotted_ipv4_address_parser_top_test
	import ipv4p_pkg::*;
();

	typedef struct packed {
		logic [AddrWidth-1:0] address;
		logic                 bad;
	} addr_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CharWidth-1:0] char_code;
	logic                 out_valid;
	logic                 out_ready;
	logic [AddrWidth-1:0] address;
	logic                 bad_address;

	addr_result_t pending_addrs[$];
	int unsigned  error_count;
	int unsigned  chars_sent;
	bit           quiet_mode;

	// behavioral parser state
	phase_t               prs_phase;
	radix_t               prs_radix;
	logic [AddrWidth-1:0] part_value;
	logic [AddrWidth-1:0] first_value;
	logic [7:0]           second_low;
	logic [7:0]           third_low;
	logic [1:0]           closed_parts;

	dotted_ipv4_address_parser_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.address     (address),
		.bad_address (bad_address)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void clear_parser();
		prs_phase    = PH_START;
		prs_radix    = RX_DEC;
		part_value   = '0;
		first_value  = '0;
		second_low   = '0;
		third_low    = '0;
		closed_parts = '0;
	endfunction

	function automatic void close_address(logic [AddrWidth-1:0] addr, logic bad,
		logic [CharWidth-1:0] c);
		addr_result_t res;
		res.address = addr;
		res.bad     = bad;
		pending_addrs.push_back(res);
		if (c == ChNul)
			clear_parser();
		else
			prs_phase = PH_DISCARD;
	endfunction

	function automatic logic [AddrWidth-1:0] joined_parts();
		logic [AddrWidth-1:0] v;
		if (closed_parts == 2'd0)
			return part_value;
		v = {first_value[7:0], 24'h0};
		if (closed_parts > 2'd1)
			v = v | {8'h0, second_low, 16'h0};
		if (closed_parts > 2'd2)
			v = v | {16'h0, third_low, 8'h0};
		return v | part_value;
	endfunction

	// advance the parser by one accepted character
	function automatic void parse_char(logic [CharWidth-1:0] c);
		logic                 is_x;
		logic [AddrWidth-1:0] weight;
		is_x = (c == ChLowerX) || (c == ChUpperX);
		if (prs_phase == PH_DISCARD) begin
			if (c == ChNul)
				clear_parser();
			return;
		end
		if (prs_phase == PH_START) begin
			part_value = '0;
			if (c == ChZero) begin
				prs_radix = RX_OCT;
				prs_phase = PH_ZERO;
				return;
			end
			prs_phase = PH_DIGITS;
			if (is_x) begin
				prs_radix = RX_HEX;
				return;
			end
			prs_radix = RX_DEC;
		end else if (prs_phase == PH_ZERO) begin
			prs_phase = PH_DIGITS;
			if (is_x) begin
				prs_radix = RX_HEX;
				return;
			end
		end
		case (prs_radix)
			RX_HEX: weight = 32'd16;
			RX_OCT: weight = 32'd8;
			default: weight = 32'd10;
		endcase
		if (c >= ChZero && c <= ChNine) begin
			// 8 and 9 still count in octal
			part_value = part_value * weight + 32'(c - ChZero);
		end else if (prs_radix == RX_HEX && c >= ChLowerA && c <= ChLowerF) begin
			part_value = part_value * weight + 32'(c - ChLowerA) + 32'd10;
		end else if (prs_radix == RX_HEX && c >= ChUpperA && c <= ChUpperF) begin
			part_value = part_value * weight + 32'(c - ChUpperA) + 32'd10;
		end else if (c == ChDot) begin
			if (closed_parts == MaxClosedParts) begin
				close_address('1, 1'b1, c);
				return;
			end
			case (closed_parts)
				2'd0: first_value = part_value;
				2'd1: second_low = part_value[7:0];
				default: third_low = part_value[7:0];
			endcase
			closed_parts = closed_parts + 2'd1;
			prs_phase    = PH_START;
			prs_radix    = RX_DEC;
			part_value   = '0;
		end else if (c == ChNul || c == ChSpace || (c >= ChTab && c <= ChCr)) begin
			close_address(joined_parts(), 1'b0, c);
		end else begin
			close_address('1, 1'b1, c);
		end
	endfunction

	// called at a rising edge; returns at the edge of the transfer
	task automatic send_char(logic [CharWidth-1:0] c);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		do
			@(posedge clk);
		while (!in_ready);
		parse_char(c);
		chars_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic logic [CharWidth-1:0] digit_char(radix_t rad);
		int unsigned r;
		if (rad != RX_HEX)
			return ChZero + 8'($urandom_range(0, 9));
		r = $urandom_range(0, 15);
		if (r < 10)
			return ChZero + 8'(r);
		if ($urandom_range(0, 1))
			return ChLowerA + 8'(r - 10);
		return ChUpperA + 8'(r - 10);
	endfunction

	task automatic send_part();
		int unsigned n;
		radix_t      rad;
		case ($urandom_range(0, 2))
			0: rad = RX_DEC;
			1: rad = RX_OCT;
			default: rad = RX_HEX;
		endcase
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 3);
		case (rad)
			RX_DEC: begin
				if (n == 0)
					n = 1;
				send_char(ChZero + 8'($urandom_range(1, 9)));
				n--;
			end
			RX_OCT: send_char(ChZero);
			default: begin
				case ($urandom_range(0, 3))
					0: send_text("0x");
					1: send_text("0X");
					2: send_char(ChLowerX);
					default: send_char(ChUpperX);
				endcase
			end
		endcase
		repeat (n) send_char(digit_char(rad));
	endtask

	task automatic send_address();
		int unsigned nparts;
		int unsigned ws;
		bit          broken;
		nparts = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(1, 4);
		broken = ($urandom_range(0, 9) == 0);
		for (int p = 0; p < nparts; p++) begin
			if (p > 0)
				send_char(ChDot);
			send_part();
			if (broken && p == 0)
				send_char(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) < 6) begin
			send_char(ChNul);
		end else begin
			ws = $urandom_range(0, 5);
			send_char(ws == 5 ? ChSpace : ChTab + 8'(ws));
			// text after the terminator is dropped through the next nul
			repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(1, 255)));
			send_char(ChNul);
		end
	endtask

	task automatic test_directed_forms();
		// four parts in mixed radix, whitespace end, then trailing junk
		send_text("0x7F.0Xa.017.9\n");
		send_text("z");
		send_char(ChNul);
		// empty text
		send_char(ChNul);
		// bare x with no digits, octal with 8 and 9, then a fifth part
		send_text("x.089.1.2.3");
		send_char(ChNul);
		// stray letter, then the top code
		send_text("1g");
		send_char(ChNul);
		send_char(8'hff);
		send_char(ChNul);
	endtask

	task automatic test_random_addresses(int unsigned count);
		int unsigned target;
		target = chars_sent + count;
		while (chars_sent < target) begin
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
			else
				send_address();
		end
		// leave the parser at the start of a text
		send_char(ChNul);
	endtask

	task automatic test_back_to_back(int unsigned count);
		quiet_mode = 1'b1;
		test_random_addresses(count);
		quiet_mode = 1'b0;
	endtask

	// receiver stalls
	initial begin
		int unsigned run;
		int unsigned stall;
		forever begin
			out_ready <= 1'b1;
			run = $urandom_range(1, 12);
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		addr_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_addrs.size() == 0) begin
				$display("%0t: unexpected result address %h bad %b", $time,
					address, bad_address);
				error_count++;
			end else begin
				want = pending_addrs.pop_front();
				if (address !== want.address) begin
					$display("%0t: address expected %h actual %h", $time,
						want.address, address);
					error_count++;
				end
				if (bad_address !== want.bad) begin
					$display("%0t: bad_address expected %b actual %b", $time,
						want.bad, bad_address);
					error_count++;
				end
			end
		end
	end

	initial begin
		error_count = 0;
		chars_sent  = 0;
		quiet_mode  = 1'b0;
		clear_parser();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		char_code <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_forms();
		test_random_addresses(280);
		test_back_to_back(70);
		test_random_addresses(160);

		in_valid <= 1'b0;
		while (pending_addrs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_addrs.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_addrs.size());
			error_count++;
		end
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("simulation failed");
		$finish;
	end

endmodule
